/* rtl/clt_pkg.sv */
// Shared types, codes and character constants of the command line tokenizer.
package clt_pkg;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;
  localparam logic [1:0] CMD_EOL  = 2'd2;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_LONG_LINE  = 3'd2;
  localparam logic [2:0] ST_MANY_ARGS  = 3'd3;
  localparam logic [2:0] ST_BAD_ESCAPE = 3'd4;
  localparam logic [2:0] ST_LONG_TOKEN = 3'd5;
  localparam logic [2:0] ST_OPEN_QUOTE = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] arg_char;
    logic [3:0] arg_index;
    logic       token_end;
    logic       line_end;
    logic [2:0] status;
    logic [4:0] arg_count;
  } clt_result_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

/* rtl/clt_parser.sv */
// Tokenizer state registers and the combinational parse step for one byte command.
module clt_parser #(
  parameter int MAX_LINE  = 256,
  parameter int MAX_ARGS  = 16,
  parameter int MAX_TOKEN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          line_byte_i,
  output clt_pkg::clt_result_t result_o
);

  localparam int LLW = $clog2(MAX_LINE + 2);
  localparam int TLW = $clog2(MAX_TOKEN + 1);
  localparam int ACW = $clog2(MAX_ARGS + 1);

  logic           in_token_q, in_token_d;
  logic [1:0]     quote_q, quote_d;
  logic           esc_q, esc_d;
  logic [TLW-1:0] tok_len_q, tok_len_d;
  logic [ACW-1:0] argc_q, argc_d;
  logic [LLW-1:0] line_len_q, line_len_d;
  logic [2:0]     err_q, err_d;
  logic           halted_q, halted_d;

  always_comb begin
    clt_pkg::clt_result_t res;
    logic       take;
    logic       eol;
    logic [1:0] kind;
    logic       is_quote;

    res        = '0;
    in_token_d = in_token_q;
    quote_d    = quote_q;
    esc_d      = esc_q;
    tok_len_d  = tok_len_q;
    argc_d     = argc_q;
    line_len_d = line_len_q;
    err_d      = err_q;
    halted_d   = halted_q;
    take       = (cmd_i == clt_pkg::CMD_BYTE) || (cmd_i == clt_pkg::CMD_LAST);
    eol        = (cmd_i != clt_pkg::CMD_BYTE);
    is_quote   = (line_byte_i == clt_pkg::CH_SQUOTE) || (line_byte_i == clt_pkg::CH_DQUOTE);
    kind       = (line_byte_i == clt_pkg::CH_SQUOTE) ? clt_pkg::QUOTE_SINGLE
                                                     : clt_pkg::QUOTE_DOUBLE;

    if (take) begin
      if (line_len_q < LLW'(MAX_LINE)) begin
        line_len_d = line_len_q + LLW'(1);
        if (err_q == clt_pkg::ST_OK && !halted_q) begin
          if (line_byte_i == clt_pkg::CH_NUL) begin
            halted_d = 1'b1;
            if (esc_q) begin
              err_d = clt_pkg::ST_BAD_ESCAPE;
            end else if (quote_q != clt_pkg::QUOTE_NONE) begin
              err_d = clt_pkg::ST_OPEN_QUOTE;
            end else if (in_token_q) begin
              res.token_end = 1'b1;
              res.arg_index = 4'(argc_q);
              argc_d        = argc_q + ACW'(1);
              in_token_d    = 1'b0;
            end
          end else if (esc_q) begin
            esc_d = 1'b0;
            if (tok_len_q >= TLW'(MAX_TOKEN)) begin
              err_d = clt_pkg::ST_LONG_TOKEN;
            end else begin
              res.char_valid = 1'b1;
              res.arg_char   = line_byte_i;
              res.arg_index  = 4'(argc_q);
              tok_len_d      = tok_len_q + TLW'(1);
            end
          end else if (!in_token_q && clt_pkg::is_sep(line_byte_i)) begin
            err_d = err_q;
          end else if (!in_token_q && argc_q >= ACW'(MAX_ARGS)) begin
            err_d = clt_pkg::ST_MANY_ARGS;
          end else begin
            in_token_d = 1'b1;
            if (!in_token_q) begin
              tok_len_d = '0;
              quote_d   = clt_pkg::QUOTE_NONE;
            end
            if (quote_d == clt_pkg::QUOTE_NONE && clt_pkg::is_sep(line_byte_i)) begin
              res.token_end = 1'b1;
              res.arg_index = 4'(argc_q);
              argc_d        = argc_q + ACW'(1);
              in_token_d    = 1'b0;
            end else if (line_byte_i == clt_pkg::CH_BSLASH) begin
              esc_d = 1'b1;
            end else if (is_quote && quote_d == clt_pkg::QUOTE_NONE) begin
              quote_d = kind;
            end else if (is_quote && quote_d == kind) begin
              quote_d = clt_pkg::QUOTE_NONE;
            end else if (tok_len_d >= TLW'(MAX_TOKEN)) begin
              err_d = clt_pkg::ST_LONG_TOKEN;
            end else begin
              res.char_valid = 1'b1;
              res.arg_char   = line_byte_i;
              res.arg_index  = 4'(argc_q);
              tok_len_d      = tok_len_d + TLW'(1);
            end
          end
        end
      end else begin
        line_len_d = LLW'(MAX_LINE + 1);
        err_d      = clt_pkg::ST_LONG_LINE;
      end
    end

    if (eol) begin
      if (err_d == clt_pkg::ST_OK && !halted_d) begin
        if (esc_d) begin
          err_d = clt_pkg::ST_BAD_ESCAPE;
        end else if (quote_d != clt_pkg::QUOTE_NONE) begin
          err_d = clt_pkg::ST_OPEN_QUOTE;
        end else if (in_token_d) begin
          res.token_end = 1'b1;
          res.arg_index = 4'(argc_d);
          argc_d        = argc_d + ACW'(1);
        end
      end
      res.line_end = 1'b1;
      if (line_len_d > LLW'(MAX_LINE)) begin
        res.status = clt_pkg::ST_LONG_LINE;
      end else if (err_d != clt_pkg::ST_OK) begin
        res.status = err_d;
      end else if (argc_d == '0) begin
        res.status = clt_pkg::ST_EMPTY;
      end else begin
        res.status = clt_pkg::ST_OK;
      end
      res.arg_count = 5'(argc_d);
      in_token_d    = 1'b0;
      quote_d       = clt_pkg::QUOTE_NONE;
      esc_d         = 1'b0;
      tok_len_d     = '0;
      argc_d        = '0;
      line_len_d    = '0;
      err_d         = clt_pkg::ST_OK;
      halted_d      = 1'b0;
    end

    result_o = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      quote_q    <= clt_pkg::QUOTE_NONE;
      esc_q      <= 1'b0;
      tok_len_q  <= '0;
      argc_q     <= '0;
      line_len_q <= '0;
      err_q      <= clt_pkg::ST_OK;
      halted_q   <= 1'b0;
    end else if (advance_i) begin
      in_token_q <= in_token_d;
      quote_q    <= quote_d;
      esc_q      <= esc_d;
      tok_len_q  <= tok_len_d;
      argc_q     <= argc_d;
      line_len_q <= line_len_d;
      err_q      <= err_d;
      halted_q   <= halted_d;
    end
  end

endmodule

/* rtl/command_line_tokenizer_core.sv */
// Top level of the command line tokenizer: input register, parse step, result register.
//
//  channel  direction  tdata                       tuser                   tlast
//  s_axis   in         line_byte[7:0]              cmd[1:0]                -
//  m_axis   out        arg_char, arg_index,        char_valid, token_end   line_end
//                      status, arg_count
//
//  Input register, then result register; one byte per cycle unless the result stalls.
//  The parse state update for one byte is a single registered step, which sets that rate.
//  Reset clears the input and result stages and all parse state; a new line starts clean.
//  A stalled result holds the input stage, which then drops s_axis_tready.
module command_line_tokenizer_core #(
  parameter int MAX_LINE  = 256,
  parameter int MAX_ARGS  = 16,
  parameter int MAX_TOKEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // line_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // arg_char[7:0], arg_index[11:8], status[14:12],
                                      // arg_count[19:15], zero[23:20]
  output logic [1:0]  m_axis_tuser,   // char_valid[0], token_end[1]
  output logic        m_axis_tlast    // line_end
);

  logic                 in_valid_q;
  logic [1:0]           in_cmd_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  clt_pkg::clt_result_t out_q;
  clt_pkg::clt_result_t step_res;
  logic                 advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  clt_parser #(
    .MAX_LINE  (MAX_LINE),
    .MAX_ARGS  (MAX_ARGS),
    .MAX_TOKEN (MAX_TOKEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .cmd_i       (in_cmd_q),
    .line_byte_i (in_byte_q),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.arg_count, out_q.status, out_q.arg_index, out_q.arg_char};
  assign m_axis_tuser  = {out_q.token_end, out_q.char_valid};
  assign m_axis_tlast  = out_q.line_end;

  a_mid_line_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[19:12] == 8'd0)
    else $error("status or count set on a result that does not close the line");

  a_no_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("argument byte set without char_valid");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_cmd_q))
    else $error("input stage changed while the result side stalled");

endmodule

/* bench/command_line_tokenizer_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the command line tokenizer core: directed rows, then random lines.
module command_line_tokenizer_core_tb;

  localparam int MAX_LINE  = 256;
  localparam int MAX_ARGS  = 16;
  localparam int MAX_TOKEN = 64;

  localparam logic [1:0] CMD_EOL_ALT = 2'd3;

  localparam int ITEM_TARGET = 1700;
  localparam int IDLE_PCT    = 34;
  localparam int HOLD_START  = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_START  = 1500;
  localparam int CALM_END    = 2300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [7:0]           data;
    logic                 typed;
    clt_pkg::clt_result_t want;
  } line_item_t;

  localparam int N_ROWS = 25;
  localparam line_item_t DIRECTED_ROWS [N_ROWS] = '{
    '{clt_pkg::CMD_EOL, 8'h00, 1'b1,
      '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1, clt_pkg::ST_EMPTY, 5'd0}},
    '{clt_pkg::CMD_BYTE, 8'h61, 1'b1,
      '{1'b1, 8'h61, 4'd0, 1'b0, 1'b0, clt_pkg::ST_OK, 5'd0}},
    '{clt_pkg::CMD_BYTE, 8'hFF, 1'b1,
      '{1'b1, 8'hFF, 4'd0, 1'b0, 1'b0, clt_pkg::ST_OK, 5'd0}},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_TAB, 1'b1,
      '{1'b0, 8'h00, 4'd0, 1'b1, 1'b0, clt_pkg::ST_OK, 5'd0}},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_SQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_DQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_SPACE,  1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_SQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_BSLASH, 1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_BSLASH, 1'b0, '0},
    '{clt_pkg::CMD_LAST, clt_pkg::CH_LF,     1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_DQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_DQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_LAST, clt_pkg::CH_NUL,    1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_BSLASH, 1'b0, '0},
    '{CMD_EOL_ALT, 8'hA5, 1'b1,
      '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1, clt_pkg::ST_BAD_ESCAPE, 5'd0}},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_DQUOTE, 1'b0, '0},
    '{clt_pkg::CMD_EOL, 8'h00, 1'b1,
      '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1, clt_pkg::ST_OPEN_QUOTE, 5'd0}},
    '{clt_pkg::CMD_BYTE, 8'h78,              1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_NUL,    1'b0, '0},
    '{clt_pkg::CMD_BYTE, 8'h79,              1'b0, '0},
    '{clt_pkg::CMD_EOL,  8'hFF,              1'b0, '0},
    '{clt_pkg::CMD_BYTE, clt_pkg::CH_CR,     1'b0, '0},
    '{clt_pkg::CMD_LAST, 8'h7E,              1'b0, '0},
    '{clt_pkg::CMD_LAST, clt_pkg::CH_SPACE, 1'b1,
      '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1, clt_pkg::ST_EMPTY, 5'd0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // line_byte[7:0]
  logic [1:0]  s_axis_tuser;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // arg_char[7:0], arg_index[11:8], status[14:12],
                               // arg_count[19:15], zero[23:20]
  logic [1:0]  m_axis_tuser;   // char_valid[0], token_end[1]
  logic        m_axis_tlast;   // line_end

  line_item_t           line_feed_q[$];
  clt_pkg::clt_result_t token_events_q[$];

  int bench_cycle = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_seen [8];

  logic       tk_in_token;
  logic       tk_escape;
  logic       tk_halted;
  logic [1:0] tk_quote;
  logic [2:0] tk_err;
  int         tk_tok_len;
  int         tk_arg_cnt;
  int         tk_line_len;
  clt_pkg::clt_result_t tk_res;

  command_line_tokenizer_core #(
    .MAX_LINE (MAX_LINE),
    .MAX_ARGS (MAX_ARGS),
    .MAX_TOKEN(MAX_TOKEN)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    bench_cycle <= bench_cycle + 1;
  end

  function automatic logic calm();
    return (bench_cycle >= CALM_START) && (bench_cycle < CALM_END);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == clt_pkg::CH_SPACE) || (b == clt_pkg::CH_TAB) ||
           (b == clt_pkg::CH_CR) || (b == clt_pkg::CH_LF);
  endfunction

  function automatic void tk_clear();
    tk_in_token = 1'b0;
    tk_escape   = 1'b0;
    tk_halted   = 1'b0;
    tk_quote    = clt_pkg::QUOTE_NONE;
    tk_err      = clt_pkg::ST_OK;
    tk_tok_len  = 0;
    tk_arg_cnt  = 0;
    tk_line_len = 0;
  endfunction

  function automatic void tk_emit(input logic [7:0] b);
    if (tk_tok_len >= MAX_TOKEN) begin
      tk_err = clt_pkg::ST_LONG_TOKEN;
    end else begin
      tk_res.char_valid = 1'b1;
      tk_res.arg_char   = b;
      tk_res.arg_index  = tk_arg_cnt[3:0];
      tk_tok_len++;
    end
  endfunction

  function automatic void tk_close();
    tk_res.token_end = 1'b1;
    tk_res.arg_index = tk_arg_cnt[3:0];
    tk_arg_cnt++;
    tk_in_token = 1'b0;
  endfunction

  function automatic void tk_finish();
    if (tk_escape) begin
      tk_err = clt_pkg::ST_BAD_ESCAPE;
    end else if (tk_quote != clt_pkg::QUOTE_NONE) begin
      tk_err = clt_pkg::ST_OPEN_QUOTE;
    end else if (tk_in_token) begin
      tk_close();
    end
  endfunction

  function automatic clt_pkg::clt_result_t tokenize_step(input logic [1:0] cmd,
                                                         input logic [7:0] b);
    logic       live;
    logic [1:0] kind;
    tk_res = '0;
    if (cmd == clt_pkg::CMD_BYTE || cmd == clt_pkg::CMD_LAST) begin
      live = 1'b1;
      if (tk_line_len < MAX_LINE) begin
        tk_line_len++;
      end else begin
        tk_line_len = MAX_LINE + 1;
        tk_err = clt_pkg::ST_LONG_LINE;
        live = 1'b0;
      end
      if (live && tk_err == clt_pkg::ST_OK && !tk_halted) begin
        if (b == clt_pkg::CH_NUL) begin
          tk_halted = 1'b1;
          tk_finish();
        end else if (tk_escape) begin
          tk_escape = 1'b0;
          tk_emit(b);
        end else begin
          if (!tk_in_token) begin
            if (is_blank(b)) begin
              live = 1'b0;
            end else if (tk_arg_cnt >= MAX_ARGS) begin
              tk_err = clt_pkg::ST_MANY_ARGS;
              live = 1'b0;
            end else begin
              tk_in_token = 1'b1;
              tk_tok_len  = 0;
              tk_quote    = clt_pkg::QUOTE_NONE;
            end
          end
          if (live) begin
            kind = (b == clt_pkg::CH_SQUOTE) ? clt_pkg::QUOTE_SINGLE :
                   (b == clt_pkg::CH_DQUOTE) ? clt_pkg::QUOTE_DOUBLE : clt_pkg::QUOTE_NONE;
            if (tk_quote == clt_pkg::QUOTE_NONE && is_blank(b)) begin
              tk_close();
            end else if (b == clt_pkg::CH_BSLASH) begin
              tk_escape = 1'b1;
            end else if (kind != clt_pkg::QUOTE_NONE && tk_quote == clt_pkg::QUOTE_NONE) begin
              tk_quote = kind;
            end else if (kind != clt_pkg::QUOTE_NONE && tk_quote == kind) begin
              tk_quote = clt_pkg::QUOTE_NONE;
            end else begin
              tk_emit(b);
            end
          end
        end
      end
    end
    if (cmd != clt_pkg::CMD_BYTE) begin
      if (tk_err == clt_pkg::ST_OK && !tk_halted) begin
        tk_finish();
      end
      tk_res.line_end = 1'b1;
      if (tk_line_len > MAX_LINE) begin
        tk_res.status = clt_pkg::ST_LONG_LINE;
      end else if (tk_err != clt_pkg::ST_OK) begin
        tk_res.status = tk_err;
      end else if (tk_arg_cnt == 0) begin
        tk_res.status = clt_pkg::ST_EMPTY;
      end else begin
        tk_res.status = clt_pkg::ST_OK;
      end
      tk_res.arg_count = tk_arg_cnt[4:0];
      tk_clear();
    end
    return tk_res;
  endfunction

  function automatic void feed(input logic [1:0] cmd, input logic [7:0] b);
    line_feed_q.push_back('{cmd, b, 1'b0, '0});
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(99) < 70) ? 8'($urandom_range(8'h21, 8'h7E))
                                    : 8'($urandom_range(1, 255));
    end while (is_blank(b) || b == clt_pkg::CH_SQUOTE || b == clt_pkg::CH_DQUOTE ||
               b == clt_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(3))
      0:       return clt_pkg::CH_SPACE;
      1:       return clt_pkg::CH_TAB;
      2:       return clt_pkg::CH_CR;
      default: return clt_pkg::CH_LF;
    endcase
  endfunction

  function automatic void build_line(input int kind);
    int         n;
    int         len;
    logic [7:0] mark;
    logic [7:0] b;
    case (kind)
      0: begin
        n = $urandom_range(0, 5);
        if ($urandom_range(3) == 0) feed(clt_pkg::CMD_BYTE, blank_byte());
        for (int t = 0; t < n; t++) begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(4))
              0, 1: repeat ($urandom_range(1, 6)) feed(clt_pkg::CMD_BYTE, plain_byte());
              2, 3: begin
                mark = ($urandom_range(1) == 0) ? clt_pkg::CH_SQUOTE : clt_pkg::CH_DQUOTE;
                feed(clt_pkg::CMD_BYTE, mark);
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++) begin
                  do b = 8'($urandom_range(1, 255));
                  while (b == mark || b == clt_pkg::CH_BSLASH);
                  feed(clt_pkg::CMD_BYTE, b);
                end
                feed(clt_pkg::CMD_BYTE, mark);
              end
              default: begin
                feed(clt_pkg::CMD_BYTE, clt_pkg::CH_BSLASH);
                feed(clt_pkg::CMD_BYTE, 8'($urandom_range(1, 255)));
              end
            endcase
          end
          repeat ($urandom_range(1, 2)) feed(clt_pkg::CMD_BYTE, blank_byte());
        end
        case ($urandom_range(15))
          0: feed(clt_pkg::CMD_BYTE, clt_pkg::CH_BSLASH);
          1: begin
            feed(clt_pkg::CMD_BYTE, clt_pkg::CH_SQUOTE);
            feed(clt_pkg::CMD_BYTE, plain_byte());
          end
          2: begin
            feed(clt_pkg::CMD_BYTE, clt_pkg::CH_NUL);
            repeat ($urandom_range(1, 4)) feed(clt_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
          end
          default: ;
        endcase
      end
      1: begin
        n = $urandom_range(MAX_ARGS - 2, MAX_ARGS + 3);
        repeat (n) begin
          feed(clt_pkg::CMD_BYTE, plain_byte());
          feed(clt_pkg::CMD_BYTE, blank_byte());
        end
      end
      2: begin
        if ($urandom_range(1) == 0) feed(clt_pkg::CMD_BYTE, clt_pkg::CH_DQUOTE);
        len = $urandom_range(MAX_TOKEN - 3, MAX_TOKEN + 4);
        repeat (len) feed(clt_pkg::CMD_BYTE, plain_byte());
      end
      3: begin
        len = $urandom_range(MAX_LINE - 4, MAX_LINE + 6);
        for (int i = 0; i < len; i++) begin
          feed(clt_pkg::CMD_BYTE, (i % 20 == 19) ? blank_byte() : plain_byte());
        end
      end
      default: begin
        repeat ($urandom_range(2, 12)) begin
          feed(($urandom_range(9) < 7) ? clt_pkg::CMD_BYTE : 2'($urandom_range(1, 3)),
               8'($urandom_range(0, 255)));
        end
      end
    endcase
    case ($urandom_range(3))
      0:       feed(clt_pkg::CMD_LAST, ($urandom_range(1) == 0) ? plain_byte() : blank_byte());
      1:       feed(clt_pkg::CMD_LAST, 8'($urandom_range(0, 255)));
      2:       feed(clt_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
      default: feed(CMD_EOL_ALT, 8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    int                   line_no;
    int                   pick;
    int                   drain;
    line_item_t           item;
    clt_pkg::clt_result_t predicted;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = clt_pkg::CMD_BYTE;
    foreach (status_seen[k]) status_seen[k] = 0;
    tk_clear();

    foreach (DIRECTED_ROWS[r]) line_feed_q.push_back(DIRECTED_ROWS[r]);
    line_no = 0;
    while (line_feed_q.size() < ITEM_TARGET) begin
      if (line_no < 4) begin
        pick = line_no;
      end else begin
        pick = $urandom_range(99);
        pick = (pick < 80) ? 0 : (pick < 87) ? 1 : (pick < 93) ? 2 : (pick < 95) ? 3 : 4;
      end
      build_line(pick);
      line_no++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < line_feed_q.size(); i++) begin
      item = line_feed_q[i];
      while (!calm() && $urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.data;
      s_axis_tuser  <= item.cmd;
      do @(posedge clk_i); while (!s_axis_tready);
      predicted = tokenize_step(item.cmd, item.data);
      token_events_q.push_back(item.typed ? item.want : predicted);
      items_sent++;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (token_events_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (token_events_q.size() != 0) begin
      $display("%0d expected results never arrived", token_events_q.size());
      errors += token_events_q.size();
    end

    $display("sent %0d transactions (%0d directed, %0d lines), checked %0d results, %0d failures",
             items_sent, N_ROWS, line_no, results_seen, errors);
    $display("line ends: ok %0d, empty %0d, long line %0d, many args %0d, bad escape %0d, %s%0d, %s%0d",
             status_seen[clt_pkg::ST_OK], status_seen[clt_pkg::ST_EMPTY],
             status_seen[clt_pkg::ST_LONG_LINE], status_seen[clt_pkg::ST_MANY_ARGS],
             status_seen[clt_pkg::ST_BAD_ESCAPE],
             "long token ", status_seen[clt_pkg::ST_LONG_TOKEN],
             "open quote ", status_seen[clt_pkg::ST_OPEN_QUOTE]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int rx_cycle;
    rx_cycle = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        m_axis_tready <= 1'b0;
      end else if (calm()) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    clt_pkg::clt_result_t got;
    clt_pkg::clt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tuser[1],
              m_axis_tlast, m_axis_tdata[14:12], m_axis_tdata[19:15]};
      results_seen++;
      if (token_events_q.size() == 0) begin
        if (errors < REPORT_MAX) begin
          $display("%0t: result with nothing expected: tdata=%h tuser=%b tlast=%b",
                   $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        errors++;
      end else begin
        want = token_events_q.pop_front();
        if (want.line_end) status_seen[want.status]++;
        if (got !== want || m_axis_tdata[23:20] !== 4'd0) begin
          if (errors < REPORT_MAX) begin
            $display("%0t: result %0d mismatch", $realtime, results_seen - 1);
            $display("  want cv=%0d ch=%h idx=%0d te=%0d le=%0d st=%0d cnt=%0d pad=0",
                     want.char_valid, want.arg_char, want.arg_index, want.token_end,
                     want.line_end, want.status, want.arg_count);
            $display("  got  cv=%0d ch=%h idx=%0d te=%0d le=%0d st=%0d cnt=%0d pad=%h",
                     got.char_valid, got.arg_char, got.arg_index, got.token_end,
                     got.line_end, got.status, got.arg_count, m_axis_tdata[23:20]);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("watchdog expired after %0d cycles", bench_cycle);
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/clt_pkg.sv
rtl/clt_parser.sv
rtl/command_line_tokenizer_core.sv
bench/command_line_tokenizer_core_tb.sv
